/* sv/beep_pattern_sequencer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the beep pattern sequencer
// Same-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BEEP_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define BEEP_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BPS_ASSERT_NOW(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("bps assertion failed");

// antecedent implies consequent in the next cycle
`define BPS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("bps assertion failed");

`endif

/* sv/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, widths and helpers of the beep pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int TIME_BITS  = 16;
	localparam int DUR_BITS   = 16;
	localparam int COUNT_BITS = 8;
	localparam int WIDE_BITS  = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;

	localparam logic [WIDE_BITS-1:0] TIME_MAX_W = WIDE_BITS'({TIME_BITS{1'b1}});

	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [DUR_BITS-1:0]   dur_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_BURST = 2'd1,
		OP_CONT  = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t    operation;
		count_t beep_count;
		dur_t   tone_ticks;
		dur_t   pause_duration;
	} cmd_item_t;

	// clamp a duration to the timer width
	function automatic time_t fit_time(input dur_t v);
		logic [WIDE_BITS-1:0] wide;
		wide = WIDE_BITS'(v);
		if (wide > TIME_MAX_W) begin
			wide = TIME_MAX_W;
		end
		return time_t'(wide);
	endfunction

endpackage

/* sv/bps_ifs.sv */
// ----------------------------------------------------------------------------
// bps channel interfaces
// Command, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface bps_cmd_if
	import bps_pkg::*;
();
	logic   valid;
	logic   ready;
	op_t    operation;
	count_t beep_count;
	dur_t   tone_ticks;
	dur_t   pause_duration;

	modport source (output valid, operation, beep_count, tone_ticks, pause_duration,
		input ready);
	modport sink (input valid, operation, beep_count, tone_ticks, pause_duration,
		output ready);
endinterface

interface bps_rsp_if
	import bps_pkg::*;
();
	logic   valid;
	logic   ready;
	logic   buzzer_level;
	logic   playing;
	count_t remaining_beeps;

	modport source (output valid, buzzer_level, playing, remaining_beeps, input ready);
	modport sink (input valid, buzzer_level, playing, remaining_beeps, output ready);
endinterface

interface bps_cfg_if;
	logic valid;
	logic ready;
	logic active_high;

	modport source (output valid, active_high, input ready);
	modport sink (input valid, active_high, output ready);
endinterface

/* sv/bps_cmd_stage.sv */
// ----------------------------------------------------------------------------
// bps_cmd_stage
// Input register: captures one command beat and holds it until the engine
// takes it. Refills in the same cycle the held beat is taken.
// ----------------------------------------------------------------------------
module bps_cmd_stage
	import bps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bps_cmd_if.sink    cmd,
	input  logic       take,
	output logic       item_valid,
	output cmd_item_t  item
);

	logic      valid_s1;
	cmd_item_t item_s1;

	assign cmd.ready  = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.operation      <= cmd.operation;
			item_s1.beep_count     <= cmd.beep_count;
			item_s1.tone_ticks     <= cmd.tone_ticks;
			item_s1.pause_duration <= cmd.pause_duration;
		end
	end

endmodule

/* sv/bps_engine.sv */
// ----------------------------------------------------------------------------
// bps_engine
// Pattern state and its combinational update; writes the result register.
// ----------------------------------------------------------------------------
`include "beep_pattern_sequencer_unit_assert.svh"

module bps_engine
	import bps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  cmd_item_t  item,
	input  logic       active_high,
	output logic       take,
	bps_rsp_if.source  rsp
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BEEP = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	phase_t phase_q, phase_n;
	time_t  elapsed_q, elapsed_n, elapsed_inc;
	count_t total_q, total_n;
	count_t done_q, done_n, done_inc;
	time_t  sound_q, sound_n;
	time_t  gap_q, gap_n;
	logic   cont_q, cont_n;

	logic   rsp_valid_q;
	logic   level_q;
	logic   playing_q;
	count_t remain_q;
	logic   fire;

	assign take = !rsp_valid_q || rsp.ready;
	assign fire = item_valid && take;

	assign rsp.valid           = rsp_valid_q;
	assign rsp.buzzer_level    = level_q;
	assign rsp.playing         = playing_q;
	assign rsp.remaining_beeps = remain_q;

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + time_t'(1);
	assign done_inc    = done_q + count_t'(1);

	always_comb begin
		phase_n   = phase_q;
		elapsed_n = elapsed_q;
		total_n   = total_q;
		done_n    = done_q;
		sound_n   = sound_q;
		gap_n     = gap_q;
		cont_n    = cont_q;
		unique case (item.operation)
			OP_TICK: begin
				if (phase_q == PH_BEEP) begin
					elapsed_n = elapsed_inc;
					if (cont_q) begin
						// zero length plays forever
						if (sound_q != '0 && elapsed_inc >= sound_q) begin
							phase_n = PH_IDLE;
							cont_n  = 1'b0;
						end
					end else if (elapsed_inc >= sound_q) begin
						done_n = done_inc;
						if (done_inc >= total_q) begin
							phase_n = PH_IDLE;
						end else begin
							phase_n   = PH_GAP;
							elapsed_n = '0;
						end
					end
				end else if (phase_q == PH_GAP) begin
					elapsed_n = elapsed_inc;
					if (elapsed_inc >= gap_q) begin
						phase_n   = PH_BEEP;
						elapsed_n = '0;
					end
				end
			end
			OP_BURST: begin
				if (item.beep_count != '0) begin
					total_n   = item.beep_count;
					done_n    = '0;
					sound_n   = fit_time(item.tone_ticks);
					gap_n     = fit_time((item.pause_duration != '0) ?
						item.pause_duration : item.tone_ticks);
					cont_n    = 1'b0;
					phase_n   = PH_BEEP;
					elapsed_n = '0;
				end
			end
			OP_CONT: begin
				sound_n   = fit_time(item.tone_ticks);
				cont_n    = 1'b1;
				phase_n   = PH_BEEP;
				elapsed_n = '0;
			end
			OP_STOP: begin
				phase_n = PH_IDLE;
				cont_n  = 1'b0;
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			elapsed_q   <= '0;
			total_q     <= '0;
			done_q      <= '0;
			sound_q     <= '0;
			gap_q       <= '0;
			cont_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q   <= phase_n;
				elapsed_q <= elapsed_n;
				total_q   <= total_n;
				done_q    <= done_n;
				sound_q   <= sound_n;
				gap_q     <= gap_n;
				cont_q    <= cont_n;
			end
			if (take) begin
				rsp_valid_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			level_q   <= (phase_n == PH_BEEP) ? active_high : !active_high;
			playing_q <= (phase_n != PH_IDLE);
			remain_q  <= cont_n ? '0 : total_n - done_n;
		end
	end

	`BPS_ASSERT_NOW(a_cont_only_beeping, clk, arst_n, cont_q, phase_q == PH_BEEP)
	`BPS_ASSERT_NOW(a_gap_has_beeps_left, clk, arst_n, phase_q == PH_GAP,
		!cont_q && (done_q < total_q))
	`BPS_ASSERT_NEXT(a_fire_gives_rsp, clk, arst_n, fire, rsp_valid_q)

endmodule

/* sv/beep_pattern_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_unit
// Buzzer beep pattern sequencer: ticks, bursts, continuous play and stop.
// ----------------------------------------------------------------------------
// Takes one command beat per cycle while the response side is ready and
// returns one response beat per command: the beat is held in the input
// register, then passes the combinational state update that writes the
// result register. The throughput is set by the pattern state loop in
// bps_engine, a saturating increment and compare per beat.
// The active_high register (reset 1) is written through cfg; ready is
// always high there, and a write is meant to land while no command is in
// flight. Durations are in ticks, one tick per tick command.
module beep_pattern_sequencer_unit
	import bps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bps_cmd_if.sink   cmd,
	bps_rsp_if.source rsp,
	bps_cfg_if.sink   cfg
);

	logic      active_high_q;
	logic      item_valid;
	cmd_item_t item;
	logic      take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			active_high_q <= cfg.active_high;
		end
	end

	bps_cmd_stage u_cmd_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	bps_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.active_high (active_high_q),
		.take        (take),
		.rsp         (rsp)
	);

endmodule

/* sim/beep_pattern_sequencer_unit_test.sv */
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_unit_test
// Self-checking bench for the buzzer sequencer. It drives tick, burst,
// continuous and stop commands with random gaps and response stalls. Each
// response beat is compared against a behavioral model of the tone state.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer_unit_test;
	import bps_pkg::*;

	typedef enum logic [1:0] {
		TONE_OFF  = 2'd0,
		TONE_ON   = 2'd1,
		TONE_REST = 2'd2
	} tone_phase_t;

	typedef struct packed {
		logic   buzzer_level;
		logic   playing;
		count_t remaining_beeps;
	} buzzer_report_t;

	logic clk;
	logic arst_n = 1'b0;

	bps_cmd_if cmd_bus ();
	bps_rsp_if rsp_bus ();
	bps_cfg_if cfg_bus ();

	beep_pattern_sequencer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// model state of the tone generator
	tone_phase_t tone_state   = TONE_OFF;
	time_t       tone_elapsed = '0;
	count_t      beeps_wanted = '0;
	count_t      beeps_played = '0;
	time_t       on_len       = '0;
	time_t       off_len      = '0;
	logic        hold_tone    = 1'b0;
	logic        pol_high     = 1'b1;

	buzzer_report_t pending_reports[$];

	int unsigned n_sent       = 0;
	int unsigned n_checked    = 0;
	int unsigned n_errors     = 0;
	int unsigned n_pol_writes = 0;
	int unsigned n_by_op[4]   = '{0, 0, 0, 0};
	logic        calm         = 1'b0;
	logic        cmd_live     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned draw_gap();
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// clamp a duration to the timer width
	function automatic time_t to_ticks(input dur_t d);
		if (DUR_BITS > TIME_BITS && (d >> TIME_BITS) != 0) begin
			return '1;
		end
		return time_t'(d);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		n_errors++;
	endtask

	// advance the model by one command and return the expected response
	task automatic predict_tone(input op_t op, input count_t cnt, input dur_t dur,
		input dur_t gap, output buzzer_report_t r);
		case (op)
			OP_TICK: begin
				if (tone_state == TONE_ON || tone_state == TONE_REST) begin
					if (tone_elapsed != '1) begin
						tone_elapsed++;
					end
					if (tone_state == TONE_ON) begin
						if (hold_tone) begin
							if (on_len != 0 && tone_elapsed >= on_len) begin
								tone_state = TONE_OFF;
								hold_tone  = 1'b0;
							end
						end else if (tone_elapsed >= on_len) begin
							beeps_played++;
							if (beeps_played >= beeps_wanted) begin
								tone_state = TONE_OFF;
							end else begin
								tone_state   = TONE_REST;
								tone_elapsed = '0;
							end
						end
					end else if (tone_elapsed >= off_len) begin
						tone_state   = TONE_ON;
						tone_elapsed = '0;
					end
				end
			end
			OP_BURST: begin
				// a zero count leaves everything as it was
				if (cnt != 0) begin
					beeps_wanted = cnt;
					beeps_played = '0;
					on_len       = to_ticks(dur);
					off_len      = to_ticks(gap != 0 ? gap : dur);
					hold_tone    = 1'b0;
					tone_state   = TONE_ON;
					tone_elapsed = '0;
				end
			end
			OP_CONT: begin
				on_len       = to_ticks(dur);
				hold_tone    = 1'b1;
				tone_state   = TONE_ON;
				tone_elapsed = '0;
			end
			default: begin
				tone_state = TONE_OFF;
				hold_tone  = 1'b0;
			end
		endcase
		r.playing         = (tone_state == TONE_ON || tone_state == TONE_REST);
		r.buzzer_level    = (tone_state == TONE_ON) ? pol_high : ~pol_high;
		r.remaining_beeps = hold_tone ? '0 : count_t'(beeps_wanted - beeps_played);
	endtask

	// model update on config and command beats, check on response beats
	always @(posedge clk) begin
		buzzer_report_t want;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				pol_high = cfg_bus.active_high;
				n_pol_writes++;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				n_checked++;
				if (pending_reports.size() == 0) begin
					report_mismatch("response beat with no expectation pending");
				end else begin
					want = pending_reports.pop_front();
					if (rsp_bus.buzzer_level !== want.buzzer_level) begin
						report_mismatch($sformatf("buzzer_level got %b expected %b",
							rsp_bus.buzzer_level, want.buzzer_level));
					end
					if (rsp_bus.playing !== want.playing) begin
						report_mismatch($sformatf("playing got %b expected %b",
							rsp_bus.playing, want.playing));
					end
					if (rsp_bus.remaining_beeps !== want.remaining_beeps) begin
						report_mismatch($sformatf("remaining_beeps got %0d expected %0d",
							rsp_bus.remaining_beeps, want.remaining_beeps));
					end
				end
			end
			if (cmd_bus.valid && cmd_bus.ready) begin
				n_by_op[cmd_bus.operation]++;
				predict_tone(cmd_bus.operation, cmd_bus.beep_count, cmd_bus.tone_ticks,
					cmd_bus.pause_duration, want);
				pending_reports.push_back(want);
			end
		end
	end

	// response side: random stall before each beat
	initial begin
		int unsigned stall;
		rsp_bus.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_bus.valid && rsp_bus.ready));
		end
	end

	task automatic send_cmd(input op_t op, input count_t cnt, input dur_t dur, input dur_t gap);
		int unsigned idle;
		idle = draw_gap();
		if (idle > 0) begin
			if (cmd_live) begin
				cmd_bus.valid <= 1'b0;
			end
			repeat (idle) @(posedge clk);
		end
		cmd_live               = 1'b1;
		cmd_bus.valid          <= 1'b1;
		cmd_bus.operation      <= op;
		cmd_bus.beep_count     <= cnt;
		cmd_bus.tone_ticks     <= dur;
		cmd_bus.pause_duration <= gap;
		do @(posedge clk); while (!cmd_bus.ready);
		n_sent++;
	endtask

	// ticks ignore the other fields, so fill them with noise
	task automatic send_tick();
		send_cmd(OP_TICK, count_t'($urandom), dur_t'($urandom), dur_t'($urandom));
	endtask

	task automatic wait_quiet();
		if (cmd_live) begin
			cmd_live      = 1'b0;
			cmd_bus.valid <= 1'b0;
		end
		while (n_checked != n_sent) @(posedge clk);
	endtask

	task automatic set_polarity(input logic high);
		wait_quiet();
		cfg_bus.active_high <= high;
		cfg_bus.valid       <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic test_idle_commands();
		send_tick();
		send_cmd(OP_STOP, 8'hff, 16'hffff, 16'hffff);
		// zero count burst is ignored
		send_cmd(OP_BURST, 8'd0, 16'hffff, 16'd0);
	endtask

	task automatic test_bursts();
		// zero pause takes the beep duration
		send_cmd(OP_BURST, 8'd2, 16'd1, 16'd0);
		repeat (3) send_tick();
		// zero length beep ends on the first tick
		send_cmd(OP_BURST, 8'd1, 16'd0, 16'd0);
		send_tick();
		send_cmd(OP_BURST, 8'd255, 16'hffff, 16'hffff);
		send_cmd(OP_STOP, 8'd0, 16'd0, 16'd0);
	endtask

	task automatic test_continuous();
		send_cmd(OP_CONT, 8'd0, 16'd0, 16'd0);
		send_tick();
		send_tick();
		send_cmd(OP_CONT, 8'hff, 16'd2, 16'hffff);
		send_tick();
		send_tick();
	endtask

	task automatic test_restart_and_stop();
		send_cmd(OP_BURST, 8'd3, 16'd2, 16'd1);
		send_tick();
		// new pattern replaces the running one
		send_cmd(OP_BURST, 8'd2, 16'd0, 16'd0);
		send_tick();
		send_tick();
		send_cmd(OP_STOP, 8'd7, 16'd7, 16'd7);
	endtask

	task automatic test_polarity();
		set_polarity(1'b0);
		send_cmd(OP_BURST, 8'd1, 16'd1, 16'd0);
		send_tick();
		set_polarity(1'b1);
		send_tick();
	endtask

	task automatic test_random_patterns();
		int unsigned first, pick, len;
		count_t cnt;
		dur_t   dur, gap;
		first = n_sent;
		while (n_sent - first < 390) begin
			if ($urandom_range(0, 15) == 0) begin
				calm = ~calm;
			end
			if ($urandom_range(0, 24) == 0) begin
				set_polarity(1'($urandom_range(0, 1)));
			end
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				cnt = ($urandom_range(0, 7) == 0) ? count_t'($urandom)
					: count_t'($urandom_range(1, 4));
				dur = ($urandom_range(0, 9) == 0) ? dur_t'($urandom)
					: dur_t'($urandom_range(0, 4));
				gap = ($urandom_range(0, 2) == 0) ? dur_t'(0)
					: (($urandom_range(0, 9) == 0) ? dur_t'($urandom)
					: dur_t'($urandom_range(1, 4)));
				send_cmd(OP_BURST, cnt, dur, gap);
				len = $urandom_range(2, 30);
				repeat (len) begin
					if ($urandom_range(0, 29) == 0) begin
						send_cmd(OP_STOP, count_t'($urandom), dur_t'($urandom),
							dur_t'($urandom));
					end else begin
						send_tick();
					end
				end
			end else if (pick < 8) begin
				dur = ($urandom_range(0, 3) == 0) ? dur_t'(0) : dur_t'($urandom_range(1, 8));
				send_cmd(OP_CONT, count_t'($urandom), dur, dur_t'($urandom));
				len = $urandom_range(0, 12);
				repeat (len) send_tick();
			end else if (pick == 8) begin
				send_cmd(OP_STOP, count_t'($urandom), dur_t'($urandom), dur_t'($urandom));
			end else begin
				send_cmd(op_t'($urandom_range(0, 3)), count_t'($urandom), dur_t'($urandom),
					dur_t'($urandom));
			end
		end
	endtask

	// endless tone, then a longest beep, each ticked and ended by the next command
	task automatic test_long_durations();
		send_cmd(OP_CONT, 8'd0, 16'd0, 16'd0);
		repeat (10) send_tick();
		send_cmd(OP_BURST, 8'd1, 16'hffff, 16'd7);
		repeat (10) send_tick();
		send_cmd(OP_STOP, 8'd0, 16'd0, 16'd0);
	endtask

	initial begin
		cmd_bus.valid          = 1'b0;
		cmd_bus.operation      = OP_TICK;
		cmd_bus.beep_count     = '0;
		cmd_bus.tone_ticks     = '0;
		cmd_bus.pause_duration = '0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.active_high    = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_commands();
		test_bursts();
		test_continuous();
		test_restart_and_stop();
		test_polarity();
		test_random_patterns();
		test_long_durations();

		wait_quiet();
		repeat (8) @(posedge clk);
		if (pending_reports.size() != 0) begin
			report_mismatch($sformatf("%0d responses never arrived", pending_reports.size()));
		end
		$display("Drove %0d ticks, %0d bursts, %0d continuous plays, %0d stops",
			n_by_op[OP_TICK], n_by_op[OP_BURST], n_by_op[OP_CONT], n_by_op[OP_STOP]);
		$display("Checked %0d responses across %0d polarity writes, %0d mismatches",
			n_checked, n_pol_writes, n_errors);
		if (n_errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/bps_pkg.sv
sv/bps_ifs.sv
sv/bps_cmd_stage.sv
sv/bps_engine.sv
sv/beep_pattern_sequencer_unit.sv
sim/beep_pattern_sequencer_unit_test.sv
